@@ rtl/core/wgit_pkg.sv @@
package wgit_pkg;

  localparam int unsigned BOARD_SIZE_DEF  = 8;
  localparam int unsigned PIXEL_WIDTH_DEF = 16;
  localparam int unsigned COEF_EXTRA      = 2;
  localparam int unsigned TILE_CELLS      = 16;

  // One row of B^T: a positive tap and a second tap with its sign.
  typedef struct packed {
    logic [1:0] idx_p;
    logic [1:0] idx_s;
    logic       neg_s;
  } bt_row_t;

  function automatic bt_row_t bt_row(input logic [1:0] i);
    bt_row_t r;
    unique case (i)
      2'd0: r = '{idx_p: 2'd0, idx_s: 2'd2, neg_s: 1'b1};
      2'd1: r = '{idx_p: 2'd1, idx_s: 2'd2, neg_s: 1'b0};
      2'd2: r = '{idx_p: 2'd2, idx_s: 2'd1, neg_s: 1'b1};
      2'd3: r = '{idx_p: 2'd1, idx_s: 2'd3, neg_s: 1'b1};
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/wgit_pix_if.sv @@
interface wgit_pix_if #(
  parameter int unsigned PIXEL_WIDTH = wgit_pkg::PIXEL_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [PIXEL_WIDTH-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

@@ rtl/core/wgit_coef_if.sv @@
interface wgit_coef_if #(
  parameter int unsigned COEF_WIDTH = wgit_pkg::PIXEL_WIDTH_DEF + wgit_pkg::COEF_EXTRA
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            tile_row;
  logic [1:0]            tile_col;
  logic [1:0]            coef_row;
  logic [1:0]            coef_col;
  logic [COEF_WIDTH-1:0] coef_value;
  logic                  last_of_tile;

  modport source (
    output valid, output tile_row, output tile_col, output coef_row, output coef_col,
    output coef_value, output last_of_tile, input ready
  );
  modport sink (
    input valid, input tile_row, input tile_col, input coef_row, input coef_col,
    input coef_value, input last_of_tile, output ready
  );
endinterface

@@ rtl/core/winograd_input_tile_transform.sv @@
// Pixel that completes no tile: input stays ready. Pixel that completes a tile: input ready
// drops while 16 reads through the single plane store port fill the tile, then 16 passes of
// the one combiner emit one coefficient per cycle while the sink is ready; ready returns once
// the last coefficient of the tile is loaded into the output register.
// Reset clears state, position and output valid; the plane store is not cleared.
module winograd_input_tile_transform #(
  parameter int unsigned BOARD_SIZE  = wgit_pkg::BOARD_SIZE_DEF,
  parameter int unsigned PIXEL_WIDTH = wgit_pkg::PIXEL_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  wgit_pix_if.sink           pix_i,
  wgit_coef_if.source        coef_o
);

  localparam int unsigned CW    = PIXEL_WIDTH + wgit_pkg::COEF_EXTRA;
  localparam int unsigned RW    = $clog2(BOARD_SIZE);
  localparam int unsigned CELLS = BOARD_SIZE * BOARD_SIZE;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned SW    = RW + 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [4:0] CNT_LOAD_END = 5'd16;
  localparam logic [3:0] CNT_EMIT_END = 4'd15;

  logic [1:0]    state_q, state_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [RW-1:0] row_q, row_d, col_q, col_d;
  logic [RW-1:0] ty_q, ty_d, tx_q, tx_d;

  logic [PIXEL_WIDTH-1:0]        mem_q [CELLS];
  logic [PIXEL_WIDTH-1:0]        rd_q;
  logic signed [PIXEL_WIDTH-1:0] x_q [wgit_pkg::TILE_CELLS];
  logic                          ld_vld_q, ld_in_q;
  logic [3:0]                    ld_idx_q;

  logic          out_vld_q;
  logic [1:0]    tr_q, tc_q, cr_q, cc_q;
  logic [CW-1:0] cv_q;
  logic          last_q;

  logic          accept, trig_r, trig_c, trig;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          rd_en, rd_inside;
  logic [SW-1:0] rd_r, rd_c;
  logic          out_load;
  logic [3:0]    ek;

  wgit_pkg::bt_row_t         rsel, csel;
  logic signed [CW-1:0]      t0, t1, t2, t3, coef;

  assign pix_i.ready = (state_q == ST_IDLE);
  assign accept      = pix_i.valid && pix_i.ready;

  assign trig_r = (row_q == RW'(BOARD_SIZE - 1)) || (!row_q[0] && row_q >= RW'(2));
  assign trig_c = (col_q == RW'(BOARD_SIZE - 1)) || (!col_q[0] && col_q >= RW'(2));
  assign trig   = trig_r && trig_c;

  assign wr_addr = AW'(row_q) * AW'(BOARD_SIZE) + AW'(col_q);

  // Tile origin is (2ty-1, 2tx-1); an off-plane position reads as zero.
  assign rd_en     = (state_q == ST_LOAD) && (cnt_q != CNT_LOAD_END);
  assign rd_r      = SW'({ty_q, 1'b0}) + SW'(cnt_q[3:2]) - SW'(1);
  assign rd_c      = SW'({tx_q, 1'b0}) + SW'(cnt_q[1:0]) - SW'(1);
  assign rd_inside = !rd_r[SW-1] && (rd_r < SW'(BOARD_SIZE))
                  && !rd_c[SW-1] && (rd_c < SW'(BOARD_SIZE));
  assign rd_addr   = AW'(rd_r[RW-1:0]) * AW'(BOARD_SIZE) + AW'(rd_c[RW-1:0]);

  assign ek       = cnt_q[3:0];
  assign out_load = (state_q == ST_EMIT) && (!out_vld_q || coef_o.ready);

  // Shared combiner: coefficient (i,j) of B^T.x.B from four taps.
  always_comb begin
    rsel = wgit_pkg::bt_row(ek[3:2]);
    csel = wgit_pkg::bt_row(ek[1:0]);
    t0 = CW'(x_q[{rsel.idx_p, csel.idx_p}]);
    t1 = CW'(x_q[{rsel.idx_p, csel.idx_s}]);
    t2 = CW'(x_q[{rsel.idx_s, csel.idx_p}]);
    t3 = CW'(x_q[{rsel.idx_s, csel.idx_s}]);
    if (csel.neg_s) begin
      t1 = -t1;
    end
    if (rsel.neg_s) begin
      t2 = -t2;
    end
    if (rsel.neg_s ^ csel.neg_s) begin
      t3 = -t3;
    end
    coef = (t0 + t1) + (t2 + t3);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    row_d   = row_q;
    col_d   = col_q;
    ty_d    = ty_q;
    tx_d    = tx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (col_q == RW'(BOARD_SIZE - 1)) begin
            col_d = '0;
            row_d = (row_q == RW'(BOARD_SIZE - 1)) ? '0 : row_q + RW'(1);
          end else begin
            col_d = col_q + RW'(1);
          end
          if (trig) begin
            ty_d    = (row_q - RW'(1)) >> 1;
            tx_d    = (col_q - RW'(1)) >> 1;
            cnt_d   = '0;
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (cnt_q == CNT_LOAD_END) begin
          cnt_d   = '0;
          state_d = ST_EMIT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          cnt_d = cnt_q + 5'd1;
          if (ek == CNT_EMIT_END) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      row_q     <= '0;
      col_q     <= '0;
      ty_q      <= '0;
      tx_q      <= '0;
      ld_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      row_q    <= row_d;
      col_q    <= col_d;
      ty_q     <= ty_d;
      tx_q     <= tx_d;
      ld_vld_q <= rd_en;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (coef_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[wr_addr] <= pix_i.pixel_value;
    end
    if (rd_en) begin
      rd_q     <= mem_q[rd_addr];
      ld_in_q  <= rd_inside;
      ld_idx_q <= cnt_q[3:0];
    end
    if (ld_vld_q) begin
      x_q[ld_idx_q] <= ld_in_q ? rd_q : '0;
    end
    if (out_load) begin
      tr_q   <= 2'(ty_q);
      tc_q   <= 2'(tx_q);
      cr_q   <= ek[3:2];
      cc_q   <= ek[1:0];
      cv_q   <= coef;
      last_q <= (ek == CNT_EMIT_END);
    end
  end

  assign coef_o.valid        = out_vld_q;
  assign coef_o.tile_row     = tr_q;
  assign coef_o.tile_col     = tc_q;
  assign coef_o.coef_row     = cr_q;
  assign coef_o.coef_col     = cc_q;
  assign coef_o.coef_value   = cv_q;
  assign coef_o.last_of_tile = last_q;

`ifndef SYNTHESIS
  a_trig_starts_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && trig) |=> (state_q == ST_LOAD && cnt_q == 5'd0))
    else $error("tile trigger did not start the load sequence");

  a_load_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD && cnt_q != CNT_LOAD_END)
      |=> (state_q == ST_LOAD && cnt_q == $past(cnt_q) + 5'd1))
    else $error("load sequencer skipped or stalled");

  a_last_closes_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && ek == CNT_EMIT_END)
      |=> (coef_o.valid && coef_o.last_of_tile && state_q == ST_IDLE))
    else $error("sixteenth coefficient not flagged or sequencer not idle");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (coef_o.valid && coef_o.last_of_tile)
      |-> (coef_o.coef_row == 2'd3 && coef_o.coef_col == 2'd3))
    else $error("last flag on a coefficient other than (3,3)");
`endif

endmodule
